[src/ofip_pkg.sv]
// Shared types and constants for the OBJ face index parser.
// Character codes, line position codes, format masks and the queue control struct.
// No dependencies.
`timescale 1ns / 1ps

package ofip_pkg;

    // Character codes recognized in a face line.
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Position within the line.
    localparam logic [1:0] BP_F     = 2'd0;  // expecting 'f'
    localparam logic [1:0] BP_SPACE = 2'd1;  // expecting the space after 'f'
    localparam logic [1:0] BP_BODY  = 2'd2;  // vertex tokens
    localparam logic [1:0] BP_DONE  = 2'd3;  // line finished, waiting for line end

    // Field presence masks: bit 0 position, bit 1 texture, bit 2 normal.
    localparam logic [2:0] FMT_V     = 3'b001;
    localparam logic [2:0] FMT_VT    = 3'b011;
    localparam logic [2:0] FMT_VN    = 3'b101;
    localparam logic [2:0] FMT_VTN   = 3'b111;

    // Result queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CNT_W = 3;

    // Writes into the result queue for one accepted byte.
    typedef struct packed {
        logic first;
        logic second;
    } ofip_push_t;

endpackage

[src/ofip_out_queue.sv]
// Four-entry result queue between the parser logic and the result channel.
// Takes up to two results per cycle and hands out one per transfer.
// Depends on ofip_pkg.
`timescale 1ns / 1ps

module ofip_out_queue
    import ofip_pkg::*;
#(
    parameter int WIDTH = 103
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ofip_push_t       push,
    input  logic [WIDTH-1:0] push_data0,
    input  logic [WIDTH-1:0] push_data1,
    output logic             room_two,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]    q_reg  [OQ_DEPTH];
    logic [WIDTH-1:0]    q_next [OQ_DEPTH];
    logic [OQ_CNT_W-1:0] count_reg;
    logic [OQ_CNT_W-1:0] count_next;
    logic [OQ_CNT_W-1:0] cnt_after_pop;
    logic                pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = q_reg[0];
    assign room_two  = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));

    // Shift out the head on a transfer, then write new results behind the survivors.
    always_comb begin
        cnt_after_pop = count_reg - OQ_CNT_W'(pop);
        for (int i = 0; i < OQ_DEPTH; i++) begin
            q_next[i] = (pop && (i < OQ_DEPTH - 1)) ? q_reg[(i + 1) % OQ_DEPTH] : q_reg[i];
            if (push.first && (cnt_after_pop == OQ_CNT_W'(i))) begin
                q_next[i] = push_data0;
            end
            if (push.second && (OQ_CNT_W'(cnt_after_pop + 1'b1) == OQ_CNT_W'(i))) begin
                q_next[i] = push_data1;
            end
        end
        count_next = cnt_after_pop + OQ_CNT_W'(push.first) + OQ_CNT_W'(push.second);
    end

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < OQ_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

[src/obj_face_index_parser.sv]
// OBJ face line parser: one text byte in per transfer, vertex index triples out.
// Accepts one byte every clock cycle. Each byte produces zero, one or two results,
// which enter a four-entry result queue; results are registered in the queue before
// they reach the master side. s_tready drops only while fewer than two queue entries
// are free, so with m_tready held high the input never stalls.
// A vertex token is reported once the following token or the end of the line is
// seen; the final result of every line carries m_tlast. A line that does not open
// with "f " gives one result with line_ok clear and all indices all ones.
// Depends on ofip_pkg and ofip_out_queue.
`timescale 1ns / 1ps

module obj_face_index_parser
    import ofip_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int INDEX_BITS   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input bytes.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    input  logic                 s_tlast,   // line_end
    // Results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // position_index, texcoord_index, normal_index (INDEX_BITS each), vertex_number (4)
    output logic [((3*INDEX_BITS+4+7)/8)*8-1:0] m_tdata,
    output logic                 m_tlast,   // last_vertex
    output logic [1:0]           m_tuser    // [0] line_ok, [1] too_many
);

    localparam int IB      = INDEX_BITS;
    localparam int DATA_W  = ((3 * IB + 4 + 7) / 8) * 8;
    localparam int RES_W   = 3 * IB + 7;
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int LAST_B  = 3 * IB + 4;

    // Parser state.
    logic [1:0]        bpos_reg,       bpos_next;
    logic [2:0]        fmask_reg,      fmask_next;
    logic              fknown_reg,     fknown_next;
    logic [1:0]        sc_reg,         sc_next;
    logic              sadj_reg,       sadj_next;
    logic [IB-1:0]     acc_reg [3];
    logic [IB-1:0]     acc_next [3];
    logic [IB-1:0]     pidx_reg [3];
    logic [IB-1:0]     pidx_next [3];
    logic [3:0]        pnum_reg,       pnum_next;
    logic              pvalid_reg,     pvalid_next;
    logic [VCNT_W-1:0] vcnt_reg,       vcnt_next;
    logic              intok_reg,      intok_next;
    logic              many_reg,       many_next;

    // Per-byte working values.
    logic              s_xfer;
    logic [7:0]        ch;
    logic              le;
    logic              sep;
    logic              is_digit;
    logic              complete;
    logic              ended;
    logic              clr_line;
    logic [1:0]        t_sc;
    logic              t_sadj;
    logic [IB-1:0]     t_acc [3];
    logic [IB-1:0]     digit;
    logic [2:0]        fm;
    logic [IB-1:0]     idx [3];
    logic [RES_W-1:0]  fin_res;
    logic [RES_W-1:0]  res0;
    logic [RES_W-1:0]  res1;
    ofip_push_t        push;

    logic [RES_W-1:0]  head;
    logic              room_two;

    // Result word layout: {too_many, line_ok, last, vertex_number, n, t, p}.
    function automatic logic [RES_W-1:0] pack_res(
        input logic [IB-1:0] p,
        input logic [IB-1:0] t,
        input logic [IB-1:0] n,
        input logic [3:0]    num,
        input logic          last,
        input logic          ok,
        input logic          many
    );
        pack_res = {many, ok, last, num, n, t, p};
    endfunction

    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = room_two;
    assign ch       = s_tdata;
    assign le       = s_tlast;
    assign sep      = (ch == CH_SPACE) || (ch == CH_NL);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = IB'(ch - CH_ZERO);

    // Next state and results for the byte on the input side.
    always_comb begin
        bpos_next   = bpos_reg;
        fmask_next  = fmask_reg;
        fknown_next = fknown_reg;
        sc_next     = sc_reg;
        sadj_next   = sadj_reg;
        acc_next    = acc_reg;
        pidx_next   = pidx_reg;
        pnum_next   = pnum_reg;
        pvalid_next = pvalid_reg;
        vcnt_next   = vcnt_reg;
        intok_next  = intok_reg;
        many_next   = many_reg;
        push        = '0;
        res0        = pack_res('1, '1, '1, 4'd0, 1'b1, 1'b0, 1'b0);
        res1        = res0;
        clr_line    = 1'b0;
        complete    = 1'b0;
        ended       = 1'b0;
        fm          = fmask_reg;
        fin_res     = res0;

        // Working copy of the token: a fresh token starts from zero.
        if (intok_reg) begin
            t_sc   = sc_reg;
            t_sadj = sadj_reg;
            t_acc  = acc_reg;
        end else begin
            t_sc   = 2'd0;
            t_sadj = 1'b0;
            for (int f = 0; f < 3; f++) begin
                t_acc[f] = '0;
            end
        end
        for (int f = 0; f < 3; f++) begin
            idx[f] = '1;
        end

        unique case (bpos_reg)
            BP_F: begin
                if (ch == CH_F && !le) begin
                    bpos_next = BP_SPACE;
                end else begin
                    push.first = 1'b1;
                    clr_line   = 1'b1;
                    bpos_next  = le ? BP_F : BP_DONE;
                end
            end
            BP_SPACE: begin
                if (ch != CH_SPACE) begin
                    push.first = 1'b1;
                    clr_line   = 1'b1;
                    bpos_next  = le ? BP_F : BP_DONE;
                end else begin
                    bpos_next = BP_BODY;
                    if (le) begin
                        push.first = 1'b1;
                        res0       = pack_res('1, '1, '1, 4'd0, 1'b1, 1'b1, many_reg);
                        clr_line   = 1'b1;
                        bpos_next  = BP_F;
                    end
                end
            end
            BP_BODY: begin
                // Update the token with a non-separator byte.
                if (!sep) begin
                    if (ch == CH_SLASH) begin
                        if (t_sc == 2'd0) begin
                            t_sadj = 1'b1;
                        end
                        if (t_sc != 2'd3) begin
                            t_sc = t_sc + 2'd1;
                        end
                    end else begin
                        if (t_sc == 2'd1) begin
                            t_sadj = 1'b0;
                        end
                        for (int f = 0; f < 3; f++) begin
                            if (is_digit && t_sc == 2'(f)) begin
                                t_acc[f] = IB'({t_acc[f], 3'b000}) + IB'({t_acc[f], 1'b0})
                                         + digit;
                            end
                        end
                    end
                    sc_next    = t_sc;
                    sadj_next  = t_sadj;
                    acc_next   = t_acc;
                    intok_next = 1'b1;
                end

                complete = sep ? intok_reg : le;
                ended    = le || (sep && (!intok_reg || ch == CH_NL));

                // Token completion: fix the format on the first token, hold the result.
                if (complete) begin
                    if (!fknown_reg) begin
                        if (t_sc == 2'd0) begin
                            fm = FMT_V;
                        end else if (t_sc == 2'd1) begin
                            fm = FMT_VT;
                        end else if (t_sc == 2'd2 && t_sadj) begin
                            fm = FMT_VN;
                        end else begin
                            fm = FMT_VTN;
                        end
                    end
                    fmask_next  = fm;
                    fknown_next = 1'b1;
                    for (int f = 0; f < 3; f++) begin
                        idx[f] = fm[f] ? (t_acc[f] - IB'(1)) : '1;
                    end
                    if (vcnt_reg < VCNT_W'(MAX_VERTICES)) begin
                        if (pvalid_reg) begin
                            push.first = 1'b1;
                            res0 = pack_res(pidx_reg[0], pidx_reg[1], pidx_reg[2], pnum_reg,
                                            1'b0, 1'b1, many_reg);
                        end
                        pidx_next   = idx;
                        pnum_next   = 4'(vcnt_reg);
                        pvalid_next = 1'b1;
                        vcnt_next   = VCNT_W'(vcnt_reg + 1'b1);
                    end else begin
                        many_next = 1'b1;
                    end
                    intok_next = 1'b0;
                    sc_next    = 2'd0;
                    sadj_next  = 1'b0;
                    for (int f = 0; f < 3; f++) begin
                        acc_next[f] = '0;
                    end
                end

                // Line end: report the held token, or an empty line.
                if (ended) begin
                    if (pvalid_next) begin
                        fin_res = pack_res(pidx_next[0], pidx_next[1], pidx_next[2],
                                           pnum_next, 1'b1, 1'b1, many_next);
                    end else begin
                        fin_res = pack_res('1, '1, '1, 4'd0, 1'b1, 1'b1, many_next);
                    end
                    if (push.first) begin
                        push.second = 1'b1;
                        res1        = fin_res;
                    end else begin
                        push.first = 1'b1;
                        res0       = fin_res;
                    end
                    clr_line  = 1'b1;
                    bpos_next = le ? BP_F : BP_DONE;
                end
            end
            BP_DONE: begin
                if (le) begin
                    clr_line  = 1'b1;
                    bpos_next = BP_F;
                end
            end
            default: begin
                bpos_next = BP_F;
            end
        endcase

        // Return all line state to its start values.
        if (clr_line) begin
            fmask_next  = '0;
            fknown_next = 1'b0;
            sc_next     = 2'd0;
            sadj_next   = 1'b0;
            for (int f = 0; f < 3; f++) begin
                acc_next[f] = '0;
            end
            pvalid_next = 1'b0;
            pnum_next   = 4'd0;
            vcnt_next   = '0;
            intok_next  = 1'b0;
            many_next   = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpos_reg   <= BP_F;
            fmask_reg  <= '0;
            fknown_reg <= 1'b0;
            sc_reg     <= 2'd0;
            sadj_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            pnum_reg   <= 4'd0;
            vcnt_reg   <= '0;
            intok_reg  <= 1'b0;
            many_reg   <= 1'b0;
            for (int f = 0; f < 3; f++) begin
                acc_reg[f] <= '0;
            end
        end else if (s_xfer) begin
            bpos_reg   <= bpos_next;
            fmask_reg  <= fmask_next;
            fknown_reg <= fknown_next;
            sc_reg     <= sc_next;
            sadj_reg   <= sadj_next;
            pvalid_reg <= pvalid_next;
            pnum_reg   <= pnum_next;
            vcnt_reg   <= vcnt_next;
            intok_reg  <= intok_next;
            many_reg   <= many_next;
            acc_reg    <= acc_next;
        end
    end

    // Held token indices; qualified by the valid bit.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pidx_reg <= pidx_next;
        end
    end

    ofip_out_queue #(
        .WIDTH (RES_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_xfer ? push : '0),
        .push_data0 (res0),
        .push_data1 (res1),
        .room_two   (room_two),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (head)
    );

    // Unpack the queue head onto the result channel.
    assign m_tdata = DATA_W'(head[LAST_B-1:0]);
    assign m_tlast = head[LAST_B];
    assign m_tuser = head[RES_W-1:LAST_B+1];

`ifndef ASSERT_OFF
    // A rejected line reports a single result with no indices.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata[IB-1:0] == '1))
        else $error("bad-opening result is not a lone all-ones last result");

    // Bytes after the end of a line produce nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && bpos_reg == BP_DONE) |-> !push.first)
        else $error("result produced after line end");

    // A second result in one cycle is always the line's final one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.second |-> (push.first && res1[LAST_B]))
        else $error("second result is not the final result of the line");

    // The vertex counter stops at the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex counter passed the limit");
`endif

endmodule
